// ----- sv/kli_pkg.sv -----
// Package for the keyframe linear interpolator.
// Holds the request, result and key entry types, codes and the state enum.
// No dependencies.
`timescale 1ns / 1ps
package kli_pkg;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [1:0] HOLD_NONE  = 2'd0;
	localparam logic [1:0] HOLD_FIRST = 2'd1;
	localparam logic [1:0] HOLD_LAST  = 2'd2;

	typedef struct packed {
		logic        operation;
		logic [5:0]  key_index;
		logic [31:0] key_time;
		logic [31:0] value_x;
		logic [31:0] value_y;
		logic [31:0] value_z;
		logic [31:0] query_time;
	} request_t;

	typedef struct packed {
		logic [31:0] out_x;
		logic [31:0] out_y;
		logic [31:0] out_z;
		logic [5:0]  segment;
		logic [1:0]  hold_mode;
	} result_t;

	typedef struct packed {
		logic [31:0] key_time;
		logic [31:0] value_x;
		logic [31:0] value_y;
		logic [31:0] value_z;
	} key_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FIRST,
		ST_SCAN,
		ST_DIV,
		ST_MUL,
		ST_ADD
	} back_state_t;

endpackage

// ----- sv/keyframe_linear_interpolator.sv -----
// Keyframe linear interpolator top level. A query held at the first key ends after
// the first table read; others scan the table one entry a cycle, up to the segment that
// holds the time or to a held last key. A segment then runs the 17-bit fraction divider
// (skipped when zero-length) and a multiply and add per component. Loads write in idle.
// Reset clears control and sets key_count to 1; the table is undefined until loaded.
// Results are strobed on done for one cycle; the receiver cannot stall.
`timescale 1ns / 1ps
module keyframe_linear_interpolator #(
	parameter int MAX_KEYS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  kli_pkg::request_t request,
	output kli_pkg::result_t  result,
	output logic              done,
	input  logic              key_count_we,
	input  logic [6:0]        key_count_wdata
);
	import kli_pkg::*;

	request_t item;
	logic     item_valid;
	logic     item_ready;

	kli_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.request    (request),
		.busy       (busy),
		.item       (item),
		.item_valid (item_valid),
		.item_ready (item_ready)
	);

	kli_back #(
		.MAX_KEYS (MAX_KEYS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.key_count_we    (key_count_we),
		.key_count_wdata (key_count_wdata),
		.item            (item),
		.item_valid      (item_valid),
		.item_ready      (item_ready),
		.result          (result),
		.done            (done)
	);

endmodule

// ----- sv/kli_front.sv -----
// Front end of the keyframe linear interpolator: accepts requests into a
// two-entry queue and hands them to the back end. Depends on kli_pkg.
`timescale 1ns / 1ps
module kli_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  kli_pkg::request_t request,
	output logic              busy,
	output kli_pkg::request_t item,
	output logic              item_valid,
	input  logic              item_ready
);
	import kli_pkg::*;

	request_t    entry_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;
	logic        push;
	logic        pop;

	assign busy       = (count_q == 2'd2);
	assign item_valid = (count_q != 2'd0);
	assign item       = entry_q[rd_ptr_q];
	assign push       = start && !busy;
	assign pop        = item_valid && item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop) count_q <= count_q + 2'd1;
			else if (pop && !push) count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= request;
	end

endmodule

// ----- sv/kli_back.sv -----
// Back end of the keyframe linear interpolator: key table memory, segment
// search, iterative fraction divider and shared multiplier. Depends on kli_pkg.
`timescale 1ns / 1ps
module kli_back #(
	parameter int MAX_KEYS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              key_count_we,
	input  logic [6:0]        key_count_wdata,
	input  kli_pkg::request_t item,
	input  logic              item_valid,
	output logic              item_ready,
	output kli_pkg::result_t  result,
	output logic              done
);
	import kli_pkg::*;

	localparam int IDX_W = $clog2(MAX_KEYS);
	localparam int CNT_W = $clog2(MAX_KEYS + 1);
	localparam logic [1:0] COMP_X = 2'd0;
	localparam logic [1:0] COMP_Y = 2'd1;
	localparam logic [1:0] COMP_Z = 2'd2;

	key_t                 mem [MAX_KEYS];
	key_t                 rdata_q;
	logic [IDX_W-1:0]     raddr;
	logic [IDX_W-1:0]     waddr;
	logic                 wr_en;

	back_state_t          state_q, state_d;
	logic [6:0]           key_count_q;
	logic [CNT_W-1:0]     n_eff;
	logic [CNT_W-1:0]     n_q;
	logic [31:0]          t_q;
	logic [IDX_W-1:0]     idx_q;
	logic [IDX_W-1:0]     seg_q;
	key_t                 prev_q;
	key_t                 cur_q;
	logic [32:0]          rem_q;
	logic [31:0]          den_q;
	logic [16:0]          frac_q;
	logic [4:0]           bit_q;
	logic [1:0]           comp_q;
	logic signed [50:0]   prod_s1;
	result_t              result_q;
	logic                 done_q;

	logic                 hit;
	logic                 last;
	logic                 early;
	logic                 ge;
	logic [31:0]          a_sel;
	logic [31:0]          b_sel;
	logic signed [32:0]   diff;
	logic signed [50:0]   adj;
	logic signed [50:0]   quo;
	logic [31:0]          sum;

	assign result = result_q;
	assign done   = done_q;

	always_comb begin
		if ({25'b0, key_count_q} > 32'(MAX_KEYS)) n_eff = CNT_W'(MAX_KEYS);
		else if (key_count_q == 7'd0) n_eff = CNT_W'(1);
		else n_eff = CNT_W'(key_count_q);
	end

	assign waddr = IDX_W'(item.key_index);
	assign wr_en = (state_q == ST_IDLE) && item_valid && (item.operation == OP_LOAD)
		&& ({26'b0, item.key_index} < 32'(MAX_KEYS));

	always_ff @(posedge clk) begin
		if (wr_en) mem[waddr] <= {item.key_time, item.value_x, item.value_y, item.value_z};
		rdata_q <= mem[raddr];
	end

	assign early = (n_q == CNT_W'(1)) || (t_q <= rdata_q.key_time);
	assign hit   = (prev_q.key_time <= t_q) && (t_q <= rdata_q.key_time);
	assign last  = ((CNT_W'(idx_q) + CNT_W'(1)) == n_q);
	assign ge    = (rem_q >= {1'b0, den_q});

	always_comb begin
		case (comp_q)
			COMP_X: begin
				a_sel = prev_q.value_x;
				b_sel = cur_q.value_x;
			end
			COMP_Y: begin
				a_sel = prev_q.value_y;
				b_sel = cur_q.value_y;
			end
			default: begin
				a_sel = prev_q.value_z;
				b_sel = cur_q.value_z;
			end
		endcase
	end

	assign diff = {b_sel[31], b_sel} - {a_sel[31], a_sel};
	assign adj  = prod_s1[50] ? (prod_s1 + 51'sd65535) : prod_s1;
	assign quo  = adj >>> 16;
	assign sum  = a_sel + quo[31:0];

	always_comb begin
		state_d    = state_q;
		item_ready = 1'b0;
		raddr      = '0;
		case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid && (item.operation == OP_QUERY)) state_d = ST_FIRST;
			end
			ST_FIRST: begin
				raddr = IDX_W'(1);
				if (early) state_d = ST_IDLE;
				else state_d = ST_SCAN;
			end
			ST_SCAN: begin
				raddr = idx_q + IDX_W'(1);
				if (hit) begin
					if (rdata_q.key_time == prev_q.key_time) state_d = ST_MUL;
					else state_d = ST_DIV;
				end else if (last) begin
					state_d = ST_IDLE;
				end
			end
			ST_DIV: begin
				if (bit_q == 5'd0) state_d = ST_MUL;
			end
			ST_MUL: begin
				state_d = ST_ADD;
			end
			ST_ADD: begin
				if (comp_q == COMP_Z) state_d = ST_IDLE;
				else state_d = ST_MUL;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			key_count_q <= 7'd1;
			done_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (key_count_we) key_count_q <= key_count_wdata;
			done_q <= ((state_q == ST_FIRST) && early)
				|| ((state_q == ST_SCAN) && !hit && last)
				|| ((state_q == ST_ADD) && (comp_q == COMP_Z));
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				t_q <= item.query_time;
				n_q <= n_eff;
			end
			ST_FIRST: begin
				prev_q <= rdata_q;
				idx_q  <= IDX_W'(1);
				result_q.out_x     <= rdata_q.value_x;
				result_q.out_y     <= rdata_q.value_y;
				result_q.out_z     <= rdata_q.value_z;
				result_q.segment   <= 6'd0;
				result_q.hold_mode <= HOLD_FIRST;
			end
			ST_SCAN: begin
				if (hit) begin
					cur_q  <= rdata_q;
					seg_q  <= idx_q - IDX_W'(1);
					rem_q  <= {1'b0, t_q - prev_q.key_time};
					den_q  <= rdata_q.key_time - prev_q.key_time;
					frac_q <= '0;
					bit_q  <= 5'd16;
					comp_q <= COMP_X;
				end else begin
					prev_q <= rdata_q;
					idx_q  <= idx_q + IDX_W'(1);
					result_q.out_x     <= rdata_q.value_x;
					result_q.out_y     <= rdata_q.value_y;
					result_q.out_z     <= rdata_q.value_z;
					result_q.segment   <= 6'(idx_q);
					result_q.hold_mode <= HOLD_LAST;
				end
			end
			ST_DIV: begin
				frac_q <= {frac_q[15:0], ge};
				rem_q  <= ge ? ((rem_q - {1'b0, den_q}) << 1) : (rem_q << 1);
				bit_q  <= bit_q - 5'd1;
			end
			ST_MUL: begin
				prod_s1 <= diff * $signed({1'b0, frac_q});
			end
			ST_ADD: begin
				case (comp_q)
					COMP_X: result_q.out_x <= sum;
					COMP_Y: result_q.out_y <= sum;
					default: result_q.out_z <= sum;
				endcase
				comp_q             <= comp_q + 2'd1;
				result_q.segment   <= 6'(seg_q);
				result_q.hold_mode <= HOLD_NONE;
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- sv/kli_checker.sv -----
// Port checker for the keyframe linear interpolator, bound to the top level.
// Depends on kli_pkg.
`timescale 1ns / 1ps
module kli_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input kli_pkg::result_t  result,
	input logic              done
);
	import kli_pkg::*;

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("back-to-back results");

	a_hold_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.hold_mode != 2'd3)) else $error("bad hold mode");

	a_first_seg: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.hold_mode == HOLD_FIRST)) |-> (result.segment == 6'd0))
		else $error("held first key with nonzero segment");

	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		($past(!arst_n) && !$past(start)) |-> !done)
		else $error("result without request");

endmodule

bind keyframe_linear_interpolator kli_checker u_kli_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.result (result),
	.done   (done)
);

// ----- dv/keyframe_linear_interpolator_test.sv -----
// Testbench for the keyframe linear interpolator: loads key tables, queries
// interpolated vectors and checks each result against an in-bench predictor.
// Depends on kli_pkg and the keyframe_linear_interpolator RTL.
`timescale 1ns / 1ps
module keyframe_linear_interpolator_test;
	import kli_pkg::*;

	localparam int NKEYS = 64;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	request_t    request;
	result_t     result;
	logic        done;
	logic        key_count_we;
	logic [6:0]  key_count_wdata;

	keyframe_linear_interpolator dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.request(request), .result(result), .done(done),
		.key_count_we(key_count_we), .key_count_wdata(key_count_wdata)
	);

	// predictor state
	logic [31:0] tbl_time [NKEYS];
	logic [31:0] tbl_x [NKEYS];
	logic [31:0] tbl_y [NKEYS];
	logic [31:0] tbl_z [NKEYS];
	logic [6:0]  keys_in_use;

	request_t pending_requests[$];
	result_t  expected_results[$];
	int       gap_left;
	int       failures;

	logic [31:0] t_list [12] = '{32'h0, 32'h0000_0100, 32'h0000_0101, 32'h0001_0100,
		32'h0001_8100, 32'h0002_0100, 32'h0002_0180, 32'h0003_0100, 32'h0020_0100,
		32'h003f_0100, 32'h003f_0101, 32'hffff_ffff};

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [31:0] blend(logic [31:0] a, logic [31:0] b, logic [16:0] frac);
		logic signed [63:0] diff;
		logic signed [63:0] prod;
		logic signed [63:0] q;
		begin
			diff = $signed({{32{b[31]}}, b}) - $signed({{32{a[31]}}, a});
			prod = diff * $signed({47'd0, frac});
			q = prod / 64'sd65536;
			blend = a + q[31:0];
		end
	endfunction

	function automatic result_t predict_query(logic [31:0] t);
		result_t r;
		int n;
		logic [31:0] t0;
		logic [31:0] t1;
		logic [63:0] fr;
		begin
			n = keys_in_use;
			if (n == 0) n = 1;
			if (n > NKEYS) n = NKEYS;
			if (n == 1 || t <= tbl_time[0]) begin
				r = '{tbl_x[0], tbl_y[0], tbl_z[0], 6'd0, HOLD_FIRST};
				return r;
			end
			for (int i = 0; i + 1 < n; i++) begin
				t0 = tbl_time[i];
				t1 = tbl_time[i + 1];
				if (t0 <= t && t <= t1) begin
					fr = 0;
					if (t1 != t0) fr = ({32'd0, t - t0} << 16) / {32'd0, t1 - t0};
					r.out_x = blend(tbl_x[i], tbl_x[i + 1], fr[16:0]);
					r.out_y = blend(tbl_y[i], tbl_y[i + 1], fr[16:0]);
					r.out_z = blend(tbl_z[i], tbl_z[i + 1], fr[16:0]);
					r.segment = i[5:0];
					r.hold_mode = HOLD_NONE;
					return r;
				end
			end
			r = '{tbl_x[n - 1], tbl_y[n - 1], tbl_z[n - 1], 6'(n - 1), HOLD_LAST};
			return r;
		end
	endfunction

	function automatic void add_request(request_t r);
		pending_requests.insert(pending_requests.size(), r);
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			gap_left <= 0;
		end else if (start && !busy) begin
			if (request.operation == OP_LOAD) begin
				tbl_time[request.key_index] = request.key_time;
				tbl_x[request.key_index] = request.value_x;
				tbl_y[request.key_index] = request.value_y;
				tbl_z[request.key_index] = request.value_z;
			end else begin
				expected_results.insert(expected_results.size(),
					predict_query(request.query_time));
			end
			start <= 1'b0;
			gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
		end else if (!start) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
			end else if (pending_requests.size() > 0) begin
				request <= pending_requests.pop_front();
				start <= 1'b1;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result %h", $time, result);
				failures++;
			end else begin
				result_t e;
				e = expected_results.pop_front();
				if (e.out_x !== result.out_x)
					$display("%0t: out_x exp %h got %h", $time, e.out_x, result.out_x);
				if (e.out_y !== result.out_y)
					$display("%0t: out_y exp %h got %h", $time, e.out_y, result.out_y);
				if (e.out_z !== result.out_z)
					$display("%0t: out_z exp %h got %h", $time, e.out_z, result.out_z);
				if (e.segment !== result.segment)
					$display("%0t: segment exp %0d got %0d", $time, e.segment, result.segment);
				if (e.hold_mode !== result.hold_mode)
					$display("%0t: hold_mode exp %0d got %0d", $time, e.hold_mode,
						result.hold_mode);
				if (e !== result) failures++;
			end
		end
	end

	function automatic request_t load_req(int k, logic [31:0] t, logic [31:0] x,
		logic [31:0] y, logic [31:0] z);
		request_t r;
		begin
			r = '0;
			r.operation = OP_LOAD;
			r.key_index = k[5:0];
			r.key_time = t;
			r.value_x = x;
			r.value_y = y;
			r.value_z = z;
			return r;
		end
	endfunction

	function automatic request_t query_req(logic [31:0] t);
		request_t r;
		begin
			r = '0;
			r.key_index = 6'($urandom());
			r.key_time = $urandom();
			r.value_x = $urandom();
			r.value_y = $urandom();
			r.value_z = $urandom();
			r.operation = OP_QUERY;
			r.query_time = t;
			return r;
		end
	endfunction

	task automatic drain();
		while (pending_requests.size() > 0 || start || expected_results.size() > 0)
			@(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	task automatic write_keys_in_use(logic [6:0] v);
		@(posedge clk);
		key_count_we <= 1'b1;
		key_count_wdata <= v;
		keys_in_use = v;
		@(posedge clk);
		key_count_we <= 1'b0;
	endtask

	initial begin
		int n;
		int mx;
		logic [31:0] t;
		logic [31:0] last_t;
		arst_n = 1'b0;
		start = 1'b0;
		request = '0;
		key_count_we = 1'b0;
		key_count_wdata = 7'd1;
		keys_in_use = 7'd1;
		failures = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: full table with extremes, zero-length segment, bounds
		for (int k = 0; k < NKEYS; k++)
			add_request(load_req(k, (k == 0) ? 32'h0000_0100 :
				32'h0000_0100 + 32'h0001_0000 * ((k == 2) ? 1 : k),
				(k % 2) ? 32'h7fff_ffff : 32'h8000_0000,
				(k % 2) ? 32'h8000_0000 : 32'h7fff_ffff, $urandom()));
		add_request(query_req(32'h0000_8000));
		drain();
		write_keys_in_use(7'd64);
		foreach (t_list[i]) add_request(query_req(t_list[i]));
		drain();
		write_keys_in_use(7'd0);
		add_request(query_req(32'h0010_0000));
		drain();
		write_keys_in_use(7'd127);
		add_request(query_req(32'hffff_ffff));
		drain();

		// random phases: rebuild a table (sorted unless its times are random), then query it
		for (int ph = 0; ph < 23; ph++) begin
			n = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 8);
			write_keys_in_use(n[6:0]);
			mx = $urandom_range(0, 2);
			last_t = (mx == 0) ? 32'd0 : $urandom_range(0, 32'h0010_0000);
			for (int k = 0; k < n; k++) begin
				t = (mx == 2) ? $urandom() : last_t + (($urandom_range(0, 4) == 0) ? 0 :
					$urandom_range(1, (mx == 1) ? 32'h0000_1000 : 32'h0100_0000));
				if (t < last_t && mx != 2) t = last_t;
				last_t = t;
				add_request(load_req(k, t, $urandom(), $urandom(), $urandom()));
			end
			for (int q = 0; q < 20; q++) begin
				if ($urandom_range(0, 9) == 0)
					add_request(load_req($urandom_range(0, n - 1),
						$urandom(), $urandom(), $urandom(), $urandom()));
				else if ($urandom_range(0, 3) == 0)
					add_request(query_req($urandom()));
				else
					add_request(query_req(
						last_t - $urandom_range(0, last_t > 32'h0200_0000 ?
							32'h0200_0000 : last_t) + $urandom_range(0, 16)));
			end
			if (ph % 10 == 9 || ph % 3 == 0) drain();
			else begin
				while (pending_requests.size() > 0 || start) @(posedge clk);
				drain();
			end
		end
		drain();
		if (failures == 0)
			$display("[keyframe_linear_interpolator] OK");
		else
			$display("[keyframe_linear_interpolator] ERROR");
		$finish;
	end

	initial begin
		#20ms;
		$display("[keyframe_linear_interpolator] ERROR");
		$finish;
	end

endmodule
